// ===== src/pbbt_pkg.sv =====
// shared constants, codes and types for the predictive thermostat
`timescale 1ns / 1ps
`default_nettype none
package pbbt_pkg;

	// reading and slope formats
	localparam int TEMP_BITS       = 12;
	localparam int SLOPE_FRAC_BITS = 8;
	// slope holds scaled reading differences plus sign and margin
	localparam int SLOPE_W = TEMP_BITS + SLOPE_FRAC_BITS + 2;
	// 205 * slope before the divide by 256
	localparam int PROD_W  = SLOPE_W + 8;
	// 51 * reading difference
	localparam int DIFFP_W = TEMP_BITS + 7;

	// configuration register widths
	localparam int CFG_SP_W   = 10;
	localparam int CFG_HYST_W = 8;
	localparam int CFG_DATA_W = 10;
	localparam int CFG_IDX_W  = 1;

	// prediction and band limits share one signed width
	localparam int PRED_W  = SLOPE_W + 5;
	localparam int BOUND_W = CFG_SP_W + 3 + SLOPE_FRAC_BITS + 1;
	localparam int CMP_W   = (PRED_W > BOUND_W) ? PRED_W : BOUND_W;
	// width for the start decision compare
	localparam int LIM_W   = (TEMP_BITS > CFG_SP_W + 2) ? TEMP_BITS : CFG_SP_W + 2;

	// filter weights out of 256 and lookahead in samples
	localparam logic signed [PROD_W-1:0]  W_OLD     = PROD_W'(205);
	localparam logic signed [DIFFP_W-1:0] W_NEW     = DIFFP_W'(51);
	localparam logic signed [CMP_W-1:0]   LOOKAHEAD = CMP_W'(10);
	localparam int WEIGHT_SHIFT = 8;

	localparam logic [CFG_HYST_W-1:0] HYST_RESET = CFG_HYST_W'(2);

	// item modes
	localparam logic [1:0] MODE_SAMPLE = 2'd0;
	localparam logic [1:0] MODE_START  = 2'd1;
	localparam logic [1:0] MODE_STOP   = 2'd2;

	// run states
	localparam logic [1:0] RUN_STOPPED = 2'd0;
	localparam logic [1:0] RUN_HEAT    = 2'd1;
	localparam logic [1:0] RUN_COOL    = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HYST     = 1'd1;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_MUL    = 5'b00010,
		ST_SLOPE  = 5'b00100,
		ST_PRED   = 5'b01000,
		ST_DECIDE = 5'b10000
	} state_t;

	typedef struct packed {
		logic load_in;
		logic do_mul;
		logic do_slope;
		logic do_pred;
		logic do_decide;
	} cmd_t;

	typedef struct packed {
		logic sample;
	} status_t;

endpackage
`default_nettype wire

// ===== src/predictive_bang_bang_thermostat.sv =====
// top level of the predictive bang-bang thermostat
`timescale 1ns / 1ps
`default_nettype none
//
// channel  direction  handshake              word
// in       sink       in_valid / in_ready    mode, temperature_quarter
// out      source     out_valid / out_ready  relay_on, run_state, last_temperature
// cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a sample word passes through five controller steps: accept, the two constant
// multiplies of the slope filter, the slope update, the prediction multiply-add
// and the band compare, where the result word is registered
// start, stop and unused modes go from accept through an empty multiply step to the decision
// one word is in flight at a time; the next is taken once the controller is
// back in idle, while the previous result may still sit in the output register
// a stalled output holds the decision step until the register frees up
// reset clears the slope, the previous reading, the run state and the relay,
// sets setpoint 0 and hysteresis 2; configuration writes are taken every cycle
//
module predictive_bang_bang_thermostat (
	input  wire                                clk,
	input  wire                                arst_n,
	// sample and command words
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire [1:0]                          mode,
	input  wire [pbbt_pkg::TEMP_BITS-1:0]      temperature_quarter,
	// result words
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic                               relay_on,
	output logic [1:0]                         run_state,
	output logic [pbbt_pkg::TEMP_BITS-1:0]     last_temperature,
	// register writes
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire [pbbt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [pbbt_pkg::CFG_DATA_W-1:0]     cfg_data
);

	pbbt_pkg::cmd_t    cmd;
	pbbt_pkg::status_t stat;

	// registers are plain flops, always writable
	assign cfg_ready = 1'b1;

	// sequencer: steps a sample through multiply, slope, predict and decide
	pbbt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath: filter state, prediction, hysteresis decision, result word
	pbbt_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.stat                (stat),
		.mode                (mode),
		.temperature_quarter (temperature_quarter),
		.cfg_we              (cfg_valid & cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.relay_on            (relay_on),
		.run_state           (run_state),
		.last_temperature    (last_temperature)
	);

endmodule
`default_nettype wire

// ===== src/pbbt_ctrl.sv =====
// sequencing state machine and output handshake for the thermostat
`timescale 1ns / 1ps
`default_nettype none
module pbbt_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  wire              out_ready,
	input  pbbt_pkg::status_t stat,
	output pbbt_pkg::cmd_t   cmd
);

	pbbt_pkg::state_t st_q;
	pbbt_pkg::state_t st_d;
	logic out_valid_q;
	logic slot_free;

	// the result register can be reloaded once its word is gone or leaving
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		st_d = st_q;
		cmd  = '0;
		in_ready = 1'b0;
		case (st_q)
			pbbt_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					st_d = pbbt_pkg::ST_MUL;
				end
			end
			pbbt_pkg::ST_MUL: begin
				if (stat.sample) begin
					cmd.do_mul = 1'b1;
					st_d = pbbt_pkg::ST_SLOPE;
				end else begin
					st_d = pbbt_pkg::ST_DECIDE;
				end
			end
			pbbt_pkg::ST_SLOPE: begin
				cmd.do_slope = 1'b1;
				st_d = pbbt_pkg::ST_PRED;
			end
			pbbt_pkg::ST_PRED: begin
				cmd.do_pred = 1'b1;
				st_d = pbbt_pkg::ST_DECIDE;
			end
			pbbt_pkg::ST_DECIDE: begin
				if (slot_free) begin
					cmd.do_decide = 1'b1;
					st_d = pbbt_pkg::ST_IDLE;
				end
			end
			default: begin
				st_d = pbbt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= pbbt_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cmd.do_decide) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== src/pbbt_dp.sv =====
// thermostat datapath: registers, slope filter, prediction and decision
`timescale 1ns / 1ps
`default_nettype none
module pbbt_dp (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  pbbt_pkg::cmd_t                       cmd,
	output pbbt_pkg::status_t                    stat,
	input  wire [1:0]                            mode,
	input  wire [pbbt_pkg::TEMP_BITS-1:0]        temperature_quarter,
	input  wire                                  cfg_we,
	input  wire [pbbt_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire [pbbt_pkg::CFG_DATA_W-1:0]       cfg_data,
	output logic                                 relay_on,
	output logic [1:0]                           run_state,
	output logic [pbbt_pkg::TEMP_BITS-1:0]       last_temperature
);

	localparam int T  = pbbt_pkg::TEMP_BITS;
	localparam int F  = pbbt_pkg::SLOPE_FRAC_BITS;
	localparam int SW = pbbt_pkg::SLOPE_W;
	localparam int PW = pbbt_pkg::PROD_W;
	localparam int DW = pbbt_pkg::DIFFP_W;
	localparam int CW = pbbt_pkg::CMP_W;
	localparam int LW = pbbt_pkg::LIM_W;

	// configuration
	logic [pbbt_pkg::CFG_SP_W-1:0]   sp_q;
	logic [pbbt_pkg::CFG_HYST_W-1:0] hyst_q;

	// item holding registers
	logic [1:0]   mode_q;
	logic [T-1:0] reading_q;

	// filter and control state
	logic [T-1:0]         prev_q;
	logic signed [SW-1:0] slope_q;
	logic [1:0]           run_q;
	logic                 relay_q;

	// intermediate stages
	logic signed [PW-1:0] prod_old_s1;
	logic signed [DW-1:0] prod_new_s1;
	logic signed [CW-1:0] pred_s2;

	// result word
	logic         out_relay_q;
	logic [1:0]   out_run_q;
	logic [T-1:0] out_temp_q;

	logic signed [T:0]    diff;
	logic signed [PW-1:0] sum;
	logic signed [CW-1:0] rd_scaled;
	logic signed [CW-1:0] sp_ext;
	logic signed [CW-1:0] half_ext;
	logic signed [CW-1:0] upper;
	logic signed [CW-1:0] lower;
	logic                 start_cool;
	logic [1:0]           run_d;
	logic                 relay_d;

	assign stat.sample = (mode_q == pbbt_pkg::MODE_SAMPLE);

	// reading difference against the stored previous reading
	assign diff = $signed({1'b0, reading_q}) - $signed({1'b0, prev_q});

	// 205*slope + 51*diff scaled, floor divided by 256 below
	assign sum = prod_old_s1 + (PW'(prod_new_s1) <<< F);

	assign rd_scaled = $signed(CW'({reading_q, {F{1'b0}}}));

	// band limits in quarter degrees with slope fraction bits
	assign sp_ext   = $signed(CW'(sp_q));
	assign half_ext = $signed(CW'(hyst_q[pbbt_pkg::CFG_HYST_W-1:1]));
	assign upper    = (sp_ext + half_ext) <<< (2 + F);
	assign lower    = (sp_ext - half_ext) <<< (2 + F);

	assign start_cool = LW'(prev_q) > LW'({sp_q, 2'b00});

	always_comb begin
		run_d   = run_q;
		relay_d = relay_q;
		case (mode_q)
			pbbt_pkg::MODE_SAMPLE: begin
				case (run_q)
					pbbt_pkg::RUN_HEAT: begin
						if (pred_s2 >= upper) begin
							run_d   = pbbt_pkg::RUN_COOL;
							relay_d = 1'b0;
						end else begin
							relay_d = 1'b1;
						end
					end
					pbbt_pkg::RUN_COOL: begin
						if (pred_s2 <= lower) begin
							run_d   = pbbt_pkg::RUN_HEAT;
							relay_d = 1'b1;
						end else begin
							relay_d = 1'b0;
						end
					end
					default: begin
						run_d   = pbbt_pkg::RUN_STOPPED;
						relay_d = 1'b0;
					end
				endcase
			end
			pbbt_pkg::MODE_START: begin
				run_d = start_cool ? pbbt_pkg::RUN_COOL : pbbt_pkg::RUN_HEAT;
			end
			pbbt_pkg::MODE_STOP: begin
				run_d = pbbt_pkg::RUN_STOPPED;
			end
			default: begin
				run_d = run_q;
			end
		endcase
	end

	// control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q    <= '0;
			hyst_q  <= pbbt_pkg::HYST_RESET;
			prev_q  <= '0;
			slope_q <= '0;
			run_q   <= pbbt_pkg::RUN_STOPPED;
			relay_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					pbbt_pkg::CFG_SETPOINT: sp_q <= cfg_data[pbbt_pkg::CFG_SP_W-1:0];
					pbbt_pkg::CFG_HYST:     hyst_q <= cfg_data[pbbt_pkg::CFG_HYST_W-1:0];
					default: begin
						sp_q <= sp_q;
					end
				endcase
			end
			if (cmd.do_slope) begin
				slope_q <= SW'(sum >>> pbbt_pkg::WEIGHT_SHIFT);
				prev_q  <= reading_q;
			end
			if (cmd.do_decide) begin
				run_q   <= run_d;
				relay_q <= relay_d;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			mode_q    <= mode;
			reading_q <= temperature_quarter;
		end
		if (cmd.do_mul) begin
			prod_old_s1 <= PW'(slope_q) * pbbt_pkg::W_OLD;
			prod_new_s1 <= DW'(diff) * pbbt_pkg::W_NEW;
		end
		if (cmd.do_pred) begin
			pred_s2 <= rd_scaled + CW'(slope_q) * pbbt_pkg::LOOKAHEAD;
		end
		if (cmd.do_decide) begin
			out_relay_q <= relay_d;
			out_run_q   <= run_d;
			out_temp_q  <= prev_q;
		end
	end

	assign relay_on         = out_relay_q;
	assign run_state        = out_run_q;
	assign last_temperature = out_temp_q;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for the predictive bang-bang thermostat
`timescale 1ns / 1ps
module tb;
	import pbbt_pkg::*;

	// mode 3 has no code of its own in the package, the block just echoes its state
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int TEMP_MAX = (1 << TEMP_BITS) - 1;
	// slope filter weights out of 256, lookahead in samples
	localparam longint FILTER_KEEP = 205;
	localparam longint FILTER_TAKE = 51;
	localparam longint LOOKAHEAD_SAMPLES = 10;
	localparam longint SLOPE_UNIT = longint'(1) << SLOPE_FRAC_BITS;
	// cycles with no handshake anywhere before the run is called hung
	localparam int STALL_LIMIT = 2000;
	// pause after the last result, well past the sample path through the controller
	localparam int SETTLE_CYCLES = 12;

	typedef struct packed {
		logic relay;
		logic [1:0] run;
		logic [TEMP_BITS-1:0] temp;
	} thermo_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] mode = MODE_SAMPLE;
	logic [TEMP_BITS-1:0] temperature_quarter = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic relay_on;
	logic [1:0] run_state;
	logic [TEMP_BITS-1:0] last_temperature;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_SETPOINT;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// thermostat state as the block should hold it
	logic [TEMP_BITS-1:0] ctl_prev_reading;
	logic signed [SLOPE_W-1:0] ctl_slope;
	logic [1:0] ctl_run;
	logic ctl_relay;
	logic [CFG_SP_W-1:0] ctl_setpoint;
	logic [CFG_HYST_W-1:0] ctl_hyst;

	// result words still owed by the block, oldest first
	thermo_word_t relay_reports[$];

	bit in_idle_en = 1'b1;
	bit out_idle_en = 1'b1;
	int error_count = 0;
	int quiet_cycles = 0;

	predictive_bang_bang_thermostat dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.temperature_quarter(temperature_quarter),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.relay_on(relay_on),
		.run_state(run_state),
		.last_temperature(last_temperature),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// one step of the controller: slope filter, lookahead, band compare
	function automatic thermo_word_t thermostat_step(input logic [1:0] m,
			input logic [TEMP_BITS-1:0] t);
		longint reading, diff, half, sp, upper, lower, pred, acc;
		thermo_word_t w;
		sp = longint'(ctl_setpoint);
		half = longint'(ctl_hyst >> 1);
		case (m)
			MODE_SAMPLE: begin
				reading = longint'(t);
				diff = reading - longint'(ctl_prev_reading);
				// arithmetic shift of a signed value is the floor divide
				acc = FILTER_KEEP * longint'(ctl_slope) + FILTER_TAKE * diff * SLOPE_UNIT;
				ctl_slope = SLOPE_W'(acc >>> WEIGHT_SHIFT);
				ctl_prev_reading = t;
				pred = reading * SLOPE_UNIT + LOOKAHEAD_SAMPLES * longint'(ctl_slope);
				// band edges in quarter degrees with the slope fraction, lower may go negative
				upper = (sp + half) * 4 * SLOPE_UNIT;
				lower = (sp - half) * 4 * SLOPE_UNIT;
				if (ctl_run == RUN_HEAT) begin
					if (pred >= upper) begin
						ctl_run = RUN_COOL;
						ctl_relay = 1'b0;
					end else begin
						ctl_relay = 1'b1;
					end
				end else if (ctl_run == RUN_COOL) begin
					if (pred <= lower) begin
						ctl_run = RUN_HEAT;
						ctl_relay = 1'b1;
					end else begin
						ctl_relay = 1'b0;
					end
				end else begin
					ctl_run = RUN_STOPPED;
					ctl_relay = 1'b0;
				end
			end
			MODE_START: begin
				// relay waits for the next sample
				if (longint'(ctl_prev_reading) > sp * 4) ctl_run = RUN_COOL;
				else ctl_run = RUN_HEAT;
			end
			MODE_STOP: begin
				ctl_run = RUN_STOPPED;
			end
			default: begin
			end
		endcase
		w.relay = ctl_relay;
		w.run = ctl_run;
		w.temp = ctl_prev_reading;
		return w;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
		error_count++;
	endtask

	// present one word after a random gap, none when idling is off, and hold it until taken
	task automatic send_word(input logic [1:0] m, input logic [TEMP_BITS-1:0] t);
		int gap;
		gap = in_idle_en ? int'($urandom_range(0, 18)) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		temperature_quarter <= t;
		do @(posedge clk); while (!in_ready);
		relay_reports.push_back(thermostat_step(m, t));
	endtask

	// drop valid, let every owed word come back and the block fall idle
	task automatic settle();
		in_valid <= 1'b0;
		while (relay_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// both registers in one burst, valid held across the pair
	task automatic write_regs(input logic [CFG_DATA_W-1:0] sp_data,
			input logic [CFG_DATA_W-1:0] hyst_data);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_SETPOINT;
		cfg_data <= sp_data;
		do @(posedge clk); while (!cfg_ready);
		ctl_setpoint = sp_data[CFG_SP_W-1:0];
		cfg_index <= CFG_HYST;
		cfg_data <= hyst_data;
		do @(posedge clk); while (!cfg_ready);
		ctl_hyst = hyst_data[CFG_HYST_W-1:0];
		cfg_valid <= 1'b0;
	endtask

	// reset values, commands before any sample, swings across the band, ignored mode
	task automatic test_reset_and_commands();
		send_word(MODE_UNUSED, TEMP_BITS'(TEMP_MAX));
		send_word(MODE_START, '0);
		send_word(MODE_SAMPLE, '0);
		send_word(MODE_SAMPLE, TEMP_BITS'(TEMP_MAX));
		send_word(MODE_SAMPLE, '0);
		send_word(MODE_STOP, TEMP_BITS'(TEMP_MAX));
		// sample while stopped still moves the slope and the reading
		send_word(MODE_SAMPLE, TEMP_BITS'(2048));
		send_word(MODE_START, '0);
		send_word(MODE_SAMPLE, TEMP_BITS'(TEMP_MAX));
		send_word(MODE_UNUSED, '0);
	endtask

	// widest band at the top setpoint, then a zero band at setpoint zero
	task automatic test_register_extremes();
		settle();
		write_regs('1, '1);
		send_word(MODE_START, '0);
		send_word(MODE_SAMPLE, TEMP_BITS'(TEMP_MAX));
		send_word(MODE_SAMPLE, '0);
		send_word(MODE_SAMPLE, '0);
		send_word(MODE_SAMPLE, TEMP_BITS'(TEMP_MAX));
		send_word(MODE_STOP, '0);
		settle();
		write_regs('0, '0);
		send_word(MODE_START, '0);
		send_word(MODE_SAMPLE, '0);
		send_word(MODE_SAMPLE, TEMP_BITS'(1));
		send_word(MODE_SAMPLE, '0);
		send_word(MODE_UNUSED, '0);
	endtask

	// closed-loop plant: the reading climbs while the relay heats and falls otherwise,
	// so the prediction keeps crossing the band; commands, jumps and noise mixed in
	task automatic run_random_phase(input int n_words, input bit in_idle, input bit out_idle);
		int counted, pick, roll, cur, step;
		logic [1:0] m;
		logic [TEMP_BITS-1:0] t;
		logic [CFG_SP_W-1:0] sp_val;
		logic [CFG_HYST_W-1:0] hyst_val;
		settle();
		pick = $urandom_range(0, 9);
		if (pick == 0) sp_val = '0;
		else if (pick == 1) sp_val = '1;
		else sp_val = CFG_SP_W'($urandom_range(0, 1023));
		pick = $urandom_range(0, 9);
		if (pick == 0) hyst_val = '0;
		else if (pick == 1) hyst_val = '1;
		else if (pick < 5) hyst_val = CFG_HYST_W'($urandom_range(0, 255));
		else hyst_val = CFG_HYST_W'($urandom_range(0, 24));
		write_regs(CFG_DATA_W'(sp_val), {2'($urandom_range(0, 3)), hyst_val});
		in_idle_en = in_idle;
		out_idle_en = out_idle;
		cur = int'(sp_val) * 4 + int'($urandom_range(0, 40)) - 20;
		counted = 0;
		while (counted < n_words) begin
			pick = $urandom_range(0, 99);
			if (ctl_run == RUN_STOPPED && pick < 50) m = MODE_START;
			else if (pick < 4) m = MODE_START;
			else if (pick < 7) m = MODE_STOP;
			else if (pick < 9) m = MODE_UNUSED;
			else m = MODE_SAMPLE;
			if (m == MODE_SAMPLE) begin
				roll = $urandom_range(0, 99);
				if (roll < 2) begin
					cur = 0;
				end else if (roll < 4) begin
					cur = TEMP_MAX;
				end else if (roll < 7) begin
					cur = $urandom_range(0, TEMP_MAX);
				end else begin
					step = $urandom_range(0, 24);
					if (ctl_relay) cur += step;
					else cur -= step;
					cur += int'($urandom_range(0, 8)) - 4;
				end
				if (cur < 0) cur = 0;
				if (cur > TEMP_MAX) cur = TEMP_MAX;
				t = TEMP_BITS'(cur);
			end else begin
				// field is don't-care here, so throw anything at it
				t = TEMP_BITS'($urandom());
			end
			send_word(m, t);
			if (m != MODE_UNUSED) counted++;
		end
	endtask

	task automatic test_random_tracking();
		run_random_phase(125, 1'b1, 1'b1);
		run_random_phase(125, 1'b0, 1'b0);
		run_random_phase(125, 1'b1, 1'b0);
		run_random_phase(125, 1'b0, 1'b1);
		run_random_phase(125, 1'b1, 1'b1);
		run_random_phase(125, 1'b1, 1'b1);
	endtask

	initial begin
		// predictor starts from the reset state
		ctl_prev_reading = '0;
		ctl_slope = '0;
		ctl_run = RUN_STOPPED;
		ctl_relay = 1'b0;
		ctl_setpoint = '0;
		ctl_hyst = HYST_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_and_commands();
		test_register_extremes();
		test_random_tracking();
		settle();
		if (error_count == 0) begin
			$display("predictive_bang_bang_thermostat verification clean");
		end else begin
			$display("predictive_bang_bang_thermostat verification failed");
		end
		$finish;
	end

	// receiver: random stall before each word, none when idling is off
	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = out_idle_en ? int'($urandom_range(0, 18)) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// compare each taken word with the oldest owed one
	always @(posedge clk) begin
		thermo_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (relay_reports.size() == 0) begin
				report_mismatch("unexpected word, relay_on", relay_on, 0);
			end else begin
				want = relay_reports.pop_front();
				if (relay_on !== want.relay) report_mismatch("relay_on", relay_on, want.relay);
				if (run_state !== want.run) report_mismatch("run_state", run_state, want.run);
				if (last_temperature !== want.temp)
					report_mismatch("last_temperature", last_temperature, want.temp);
			end
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("predictive_bang_bang_thermostat verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
